### src/qgn_pkg.sv
// Shared types, constants and helpers for the quantized Gaussian int4 noise source.
// No dependencies; imported by every other file in src.
`timescale 1ns / 1ps

package qgn_pkg;

    localparam int MAX_LANES   = 8;
    localparam int WORD_W      = 32;
    localparam int NIB_W       = 4;
    localparam int EDGE_COUNT  = 14;
    localparam int LANE_W      = 3;
    localparam int WIDX_W      = 2;
    localparam int COUNT_W     = 4;

    // xoshiro128++ shift and rotate amounts
    localparam int ROT_SUM     = 7;
    localparam int SHIFT_B     = 9;
    localparam int ROT_D       = 11;

    // Offset taking the threshold count to a signed level in -7..7
    localparam logic [COUNT_W-1:0] LEVEL_OFFSET = 4'd7;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_GEN  = 1'b1;

    // State word indexes within a lane
    localparam logic [WIDX_W-1:0] WORD_A = 2'd0;
    localparam logic [WIDX_W-1:0] WORD_B = 2'd1;
    localparam logic [WIDX_W-1:0] WORD_C = 2'd2;
    localparam logic [WIDX_W-1:0] WORD_D = 2'd3;

    // Level that the quantiser never produces
    localparam logic [NIB_W-1:0] LEVEL_NEVER = 4'h8;

    // Thresholds: round(2^32 * Phi((j - 6.5) / 2.5)), at least 1
    localparam logic [WORD_W-1:0] LEVEL_EDGE [EDGE_COUNT] = '{
        32'd20019650,   32'd59714852,   32'd154319546,  32'd346847210,
        32'd681419127,  32'd1177908172, 32'd1807065788, 32'd2487901508,
        32'd3117059124, 32'd3613548169, 32'd3948120086, 32'd4140647750,
        32'd4235252444, 32'd4274947646
    };

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [NIB_W-1:0]  level_t;

    // Per-lane control for one accepted item
    typedef struct packed {
        logic              gen_en;
        logic              load_en;
        logic [WIDX_W-1:0] word_index;
    } qgn_lane_ctrl_t;

    function automatic word_t rotl32(input word_t x, input int k);
        return (x << k) | (x >> (WORD_W - k));
    endfunction

endpackage

### src/qgn_lane.sv
// One xoshiro128++ lane: 128-bit state, word load and advance, registered uniform.
// Depends on qgn_pkg.
`timescale 1ns / 1ps

module qgn_lane (
    input  logic                   clk,
    input  logic                   rst_n,
    input  qgn_pkg::qgn_lane_ctrl_t ctrl,
    input  qgn_pkg::word_t         seed_value,
    output qgn_pkg::word_t         uniform
);
    import qgn_pkg::*;

    word_t a_reg, b_reg, c_reg, d_reg;
    word_t a_next, b_next, c_next, d_next;
    word_t u_reg, u_next;
    word_t a0, r, t, a1, b1, c1, c2, d1, d2;

    always_comb
    begin
        // An all-zero lane restarts from word 0 = 1
        a0 = ((a_reg | b_reg | c_reg | d_reg) == '0) ? word_t'(1) : a_reg;
        r  = rotl32(a0 + d_reg, ROT_SUM) + a0;
        t  = b_reg << SHIFT_B;
        c1 = c_reg ^ a0;
        d1 = d_reg ^ b_reg;
        b1 = b_reg ^ c1;
        a1 = a0 ^ d1;
        c2 = c1 ^ t;
        d2 = rotl32(d1, ROT_D);
    end

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        u_next = u_reg;
        if (ctrl.load_en)
        begin
            case (ctrl.word_index)
                WORD_A:  a_next = seed_value;
                WORD_B:  b_next = seed_value;
                WORD_C:  c_next = seed_value;
                WORD_D:  d_next = seed_value;
                default: a_next = a_reg;
            endcase
        end
        else if (ctrl.gen_en)
        begin
            a_next = a1;
            b_next = b1;
            c_next = c2;
            d_next = d2;
            u_next = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
    end

    assign uniform = u_reg;

endmodule

### src/qgn_quant.sv
// Maps a 32-bit uniform to a signed level in -7..7 by threshold count.
// Depends on qgn_pkg.
`timescale 1ns / 1ps

module qgn_quant (
    input  qgn_pkg::word_t  uniform,
    output qgn_pkg::level_t level
);
    import qgn_pkg::*;

    logic [COUNT_W-1:0] count;

    always_comb
    begin
        count = '0;
        for (int j = 0; j < EDGE_COUNT; j++)
        begin
            if (uniform >= LEVEL_EDGE[j])
            begin
                count = count + COUNT_W'(1);
            end
        end
        level = count - LEVEL_OFFSET;
    end

endmodule

### src/quantized_gaussian_int4_noise_generator_top.sv
// Quantized Gaussian int4 noise source: LANES xoshiro128++ lanes, one packed word per generate.
// A generate item's uniforms are registered in the lanes, then quantised and packed into noise_word.
// Throughput: one item per cycle when not stalled; a lane's output is one add-rotate-add deep.
// Load items write one state word and give no result.
// Reset (rst_n low, asynchronous) zeroes each lane's state words and empties the pipeline.
// Depends on qgn_pkg, qgn_lane and qgn_quant.
`timescale 1ns / 1ps

module quantized_gaussian_int4_noise_generator_top #(
    parameter int LANES = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         req_type,
    input  logic [qgn_pkg::LANE_W-1:0]   lane,
    input  logic [qgn_pkg::WIDX_W-1:0]   word_index,
    input  logic [qgn_pkg::WORD_W-1:0]   seed_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [qgn_pkg::WORD_W-1:0]   noise_word
);
    import qgn_pkg::*;

    // Nibbles that belong to real lanes
    localparam logic [WORD_W-1:0] LANE_MASK =
        WORD_W'((64'd1 << (NIB_W * LANES)) - 64'd1);

    // Pipeline control: stage 1 holds the lane uniforms, stage 2 the packed word
    logic  s1_valid_reg, s1_valid_next;
    logic  out_valid_reg, out_valid_next;
    word_t noise_reg, noise_next;
    logic  out_adv, s1_adv, in_accept, gen_accept, load_accept;

    level_t levels [MAX_LANES];

    // Advance the output register when it is empty or being taken
    assign out_adv     = !out_valid_reg || !out_stall;
    // Advance stage 1 when it is empty or can move into the output register
    assign s1_adv      = !s1_valid_reg || out_adv;
    assign in_stall    = !s1_adv;
    assign in_accept   = in_valid && s1_adv;
    assign gen_accept  = in_accept && (req_type == REQ_GEN);
    assign load_accept = in_accept && (req_type == REQ_LOAD);

    genvar gl;
    generate
        for (gl = 0; gl < MAX_LANES; gl++)
        begin : g_lane
            if (gl < LANES)
            begin : g_real
                qgn_lane_ctrl_t ctrl;
                word_t          uniform;

                assign ctrl.gen_en     = gen_accept;
                assign ctrl.load_en    = load_accept && (lane == LANE_W'(gl));
                assign ctrl.word_index = word_index;

                qgn_lane u_lane (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .seed_value (seed_value),
                    .uniform    (uniform)
                );

                qgn_quant u_quant (
                    .uniform (uniform),
                    .level   (levels[gl])
                );
            end
            else
            begin : g_absent
                // Lanes beyond LANES read as zero
                assign levels[gl] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        // Only generate items enter stage 1; loads drop out here
        s1_valid_next  = s1_adv ? gen_accept : s1_valid_reg;
        out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;
        noise_next     = noise_reg;
        if (out_adv && s1_valid_reg)
        begin
            for (int l = 0; l < MAX_LANES; l++)
            begin
                noise_next[NIB_W*l +: NIB_W] = levels[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        noise_reg <= noise_next;
    end

    assign out_valid  = out_valid_reg;
    assign noise_word = noise_reg;

    // Any nibble at the level the quantiser must never give
    logic level_bad;
    always_comb
    begin
        level_bad = 1'b0;
        for (int l = 0; l < MAX_LANES; l++)
        begin
            if (noise_reg[NIB_W*l +: NIB_W] == LEVEL_NEVER)
            begin
                level_bad = 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    // A load item never reaches stage 1
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_accept |=> !s1_valid_reg)
        else $error("load item entered the result pipeline");

    // Hold input back only when both stages are full
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // Nibbles of absent lanes are zero
    a_absent_lanes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((noise_reg & ~LANE_MASK) == '0))
        else $error("absent lane nibble non-zero");

    // Level -8 never appears
    a_no_minus_eight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !level_bad)
        else $error("level -8 produced");
`endif

endmodule
